// ----- sv/sssp_pkg.sv -----
// Shared types and constants for the single-source shortest path block.
package sssp_pkg;

    localparam int unsigned APB_DATA_W   = 32;
    localparam int unsigned APB_ADDR_W   = 3;
    localparam int unsigned VCOUNT_W     = 6;
    localparam int unsigned DIST_OUT_W   = 21;
    localparam int unsigned VTX_OUT_W    = 5;
    localparam int unsigned REJECT_W     = 9;
    localparam logic [REJECT_W-1:0] REJECT_MAX = 9'd511;

    // Register index of the vertex count register.
    localparam logic CFG_IDX_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic        has_edge;
        logic [5:0]  from_vertex;
        logic [5:0]  to_vertex;
        logic [15:0] weight;
        logic        last_edge;
    } sssp_req_t;

    typedef struct packed {
        logic [VTX_OUT_W-1:0]  vertex;
        logic [DIST_OUT_W-1:0] distance;
        logic [VTX_OUT_W-1:0]  predecessor;
        logic                  has_predecessor;
        logic                  reachable;
        logic [REJECT_W-1:0]   dropped_edges;
        logic                  last_vertex;
    } sssp_res_t;

endpackage

// ----- sv/single_source_shortest_paths.sv -----
// Top level of the single-source shortest path engine (Bellman-Ford relaxation).
//
// Edges are loaded one request per cycle into an edge memory that keeps one linked
// list per start vertex, newest edge first; an edge with a start or end vertex at or
// above the vertex count, or one that arrives when the table is full, is dropped and
// counted (saturating at 511). A request with last_edge set closes the batch: after its
// own edge is stored the block stops taking requests and runs the computation from
// vertex 0. It first writes a fresh record for every vertex (n the vertex count), then
// makes relaxation passes, vertices in ascending order and each list newest first,
// improving a target only when it is unreached or on a strictly smaller distance.
// Passes stop after one that changes nothing, or after n-1 passes. In a pass each edge
// walked from a reached vertex is a read of the edge memory followed by a
// read-modify-write of the target's record in the vertex memory, both memories having
// a registered read; an edge whose target is at or above the vertex count is skipped.
// Then one result per vertex is sent in ascending order, each held until the receiver
// takes it. When the final vertex's result is taken, the edge lists and the drop count
// are cleared and the block takes requests again. Unreachable vertices report distance
// 0 and no predecessor. The vertex count is written through the APB port at address 0
// and must only change while the block is idle.
module single_source_shortest_paths
    import sssp_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    parameter int MAX_EDGES    = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  sssp_req_t             req,
    output logic                  res_valid,
    input  logic                  res_ready,
    output sssp_res_t             res
);

    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int LW  = $clog2(MAX_EDGES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DW  = 16 + VW;
    localparam int RW  = 2 + VW + DW;
    localparam int XW  = LW + 16 + VW;
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGES);

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_VRD, S_VCHK, S_ERD, S_EDAT, S_TCMP,
        S_PASS_END, S_ORD, S_OWAIT, S_OHOLD
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         n_eff;
    logic [CW-1:0]         n_m1;
    logic [VW-1:0]         v_reg;
    logic [VW-1:0]         pass_reg;
    logic                  changed_reg;
    logic [LW-1:0]         e_reg;
    logic [DW-1:0]         dv_reg;
    logic [LW-1:0]         fill_reg;
    logic [REJECT_W-1:0]   reject_reg;
    logic [LW-1:0]         head_reg [MAX_VERTICES];
    logic                  res_valid_reg;
    sssp_res_t             res_reg;

    // Edge memory: {target, weight, link}.
    logic [XW-1:0]         edge_mem [MAX_EDGES];
    logic [XW-1:0]         erd_reg;
    logic                  edge_we;
    logic [XW-1:0]         edge_wdata;

    // Vertex memory: {reached, has_pred, pred, dist}.
    logic [RW-1:0]         vrec_mem [MAX_VERTICES];
    logic [RW-1:0]         vrd_reg;
    logic                  vrec_we;
    logic [VW-1:0]         vrec_waddr;
    logic [RW-1:0]         vrec_wdata;
    logic [VW-1:0]         vrec_raddr;

    logic                  req_fire;
    logic                  edge_bad;
    logic [VW-1:0]         e_target;
    logic [15:0]           e_weight;
    logic [LW-1:0]         e_link;
    logic [DW-1:0]         rd_dist;
    logic [VW-1:0]         rd_pred;
    logic                  rd_has_pred;
    logic                  rd_reached;
    logic [DW-1:0]         cand;
    logic                  better;
    logic                  v_last;

    sssp_cfg #(.MAX_VERTICES(MAX_VERTICES)) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .n_eff   (n_eff)
    );

    assign n_m1      = n_eff - CW'(1);
    assign req_ready = (state_reg == S_LOAD);
    assign req_fire  = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign edge_bad = (7'(req.from_vertex) >= 7'(n_eff)) || (7'(req.to_vertex) >= 7'(n_eff))
                      || (fill_reg >= NULL_LINK);

    assign e_link      = erd_reg[LW-1:0];
    assign e_weight    = erd_reg[LW+15:LW];
    assign e_target    = erd_reg[XW-1:LW+16];
    assign rd_dist     = vrd_reg[DW-1:0];
    assign rd_pred     = vrd_reg[DW+VW-1:DW];
    assign rd_has_pred = vrd_reg[DW+VW];
    assign rd_reached  = vrd_reg[DW+VW+1];
    assign cand        = dv_reg + DW'(e_weight);
    assign better      = !rd_reached || (cand < rd_dist);
    assign v_last      = (CW'(v_reg) == n_m1);

    // Memory port control.
    always_comb
    begin
        edge_we    = req_fire && req.has_edge && !edge_bad;
        edge_wdata = {req.to_vertex[VW-1:0], req.weight,
                      head_reg[req.from_vertex[VW-1:0]]};
        vrec_we    = 1'b0;
        vrec_waddr = v_reg;
        vrec_wdata = '0;
        vrec_raddr = v_reg;
        case (state_reg)
            S_INIT:
            begin
                vrec_we    = 1'b1;
                vrec_wdata = {(v_reg == '0), 1'b0, VW'(0), DW'(0)};
            end
            S_EDAT:
            begin
                vrec_raddr = e_target;
            end
            S_TCMP:
            begin
                vrec_we    = better;
                vrec_waddr = e_target;
                vrec_wdata = {1'b1, 1'b1, v_reg, cand};
            end
            default:
            begin
                vrec_raddr = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[fill_reg[EW-1:0]] <= edge_wdata;
        end
        erd_reg <= edge_mem[e_reg[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (vrec_we)
        begin
            vrec_mem[vrec_waddr] <= vrec_wdata;
        end
        vrd_reg <= vrec_mem[vrec_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            v_reg         <= '0;
            pass_reg      <= '0;
            changed_reg   <= 1'b0;
            e_reg         <= NULL_LINK;
            dv_reg        <= '0;
            fill_reg      <= '0;
            reject_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                head_reg[i] <= NULL_LINK;
            end
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    if (req_fire)
                    begin
                        if (req.has_edge)
                        begin
                            if (edge_bad)
                            begin
                                if (reject_reg != REJECT_MAX)
                                begin
                                    reject_reg <= reject_reg + REJECT_W'(1);
                                end
                            end
                            else
                            begin
                                head_reg[req.from_vertex[VW-1:0]] <= fill_reg;
                                fill_reg <= fill_reg + LW'(1);
                            end
                        end
                        if (req.last_edge)
                        begin
                            v_reg     <= '0;
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    if (v_last)
                    begin
                        v_reg       <= '0;
                        pass_reg    <= '0;
                        changed_reg <= 1'b0;
                        state_reg   <= (n_eff == CW'(1)) ? S_ORD : S_VRD;
                    end
                    else
                    begin
                        v_reg <= v_reg + VW'(1);
                    end
                end
                S_VRD:
                begin
                    state_reg <= S_VCHK;
                end
                S_VCHK:
                begin
                    if (rd_reached && (head_reg[v_reg] != NULL_LINK))
                    begin
                        dv_reg    <= rd_dist;
                        e_reg     <= head_reg[v_reg];
                        state_reg <= S_ERD;
                    end
                    else if (v_last)
                    begin
                        state_reg <= S_PASS_END;
                    end
                    else
                    begin
                        v_reg     <= v_reg + VW'(1);
                        state_reg <= S_VRD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EDAT;
                end
                S_EDAT, S_TCMP:
                begin
                    if ((state_reg == S_EDAT) && (CW'(e_target) < n_eff))
                    begin
                        state_reg <= S_TCMP;
                    end
                    else
                    begin
                        if ((state_reg == S_TCMP) && better)
                        begin
                            changed_reg <= 1'b1;
                        end
                        e_reg <= e_link;
                        if (e_link != NULL_LINK)
                        begin
                            state_reg <= S_ERD;
                        end
                        else if (v_last)
                        begin
                            state_reg <= S_PASS_END;
                        end
                        else
                        begin
                            v_reg     <= v_reg + VW'(1);
                            state_reg <= S_VRD;
                        end
                    end
                end
                S_PASS_END:
                begin
                    v_reg <= '0;
                    if (!changed_reg || ((CW'(pass_reg) + CW'(1)) >= n_m1))
                    begin
                        state_reg <= S_ORD;
                    end
                    else
                    begin
                        pass_reg    <= pass_reg + VW'(1);
                        changed_reg <= 1'b0;
                        state_reg   <= S_VRD;
                    end
                end
                S_ORD:
                begin
                    state_reg <= S_OWAIT;
                end
                S_OWAIT:
                begin
                    res_reg.vertex          <= VTX_OUT_W'(v_reg);
                    res_reg.distance        <= rd_reached ? DIST_OUT_W'(rd_dist) : '0;
                    res_reg.predecessor     <= rd_has_pred ? VTX_OUT_W'(rd_pred) : '0;
                    res_reg.has_predecessor <= rd_has_pred;
                    res_reg.reachable       <= rd_reached;
                    res_reg.dropped_edges   <= reject_reg;
                    res_reg.last_vertex     <= v_last;
                    res_valid_reg           <= 1'b1;
                    state_reg               <= S_OHOLD;
                end
                S_OHOLD:
                begin
                    if (res_ready)
                    begin
                        res_valid_reg <= 1'b0;
                        if (v_last)
                        begin
                            fill_reg   <= '0;
                            reject_reg <= '0;
                            for (int i = 0; i < MAX_VERTICES; i++)
                            begin
                                head_reg[i] <= NULL_LINK;
                            end
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            v_reg     <= v_reg + VW'(1);
                            state_reg <= S_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // Loading and result delivery never overlap.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && res_valid))
        else $error("request accepted while a result is pending");

    // The edge table never holds more than its capacity.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= NULL_LINK)
        else $error("edge fill beyond capacity");

    // Taking the final result clears the batch.
    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res.last_vertex |=> (fill_reg == '0) && (reject_reg == '0))
        else $error("batch not cleared after final result");

    // A pass ends only while fewer than n-1 passes are done.
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS_END) |-> (CW'(pass_reg) < n_m1))
        else $error("relaxation pass count out of range");

    // An improved target record is always marked reached with a predecessor.
    a_rec_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TCMP) && vrec_we |-> vrec_wdata[DW+VW+1] && vrec_wdata[DW+VW])
        else $error("relaxed record written without reach flags");

endmodule

// ----- sv/sssp_cfg.sv -----
// APB register slice holding the vertex count and its clamped working value.
module sssp_cfg
    import sssp_pkg::*;
#(
    parameter int MAX_VERTICES = 32,
    localparam int CW = $clog2(MAX_VERTICES + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CW-1:0]         n_eff
);

    logic [VCOUNT_W-1:0] vertex_count_reg;
    logic                reg_sel;

    assign reg_sel = (paddr[2] == CFG_IDX_VERTEX_COUNT);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VCOUNT_W'(1);
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            vertex_count_reg <= pwdata[VCOUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = APB_DATA_W'(vertex_count_reg);
        end
    end

    // A count of zero behaves as one vertex; counts above the capacity clamp to it.
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (7'(vertex_count_reg) > 7'(MAX_VERTICES))
        begin
            n_eff = CW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = CW'(vertex_count_reg);
        end
    end

endmodule
